### rtl/fke_pkg.sv
// ----------------------------------------------------------------------------
// fke_pkg: shared definitions of the surroundings-XOR key exchange engine
// Action codes, interface widths, defaults and the controller command bundle.
// ----------------------------------------------------------------------------
package fke_pkg;

  // Interface widths fixed by the item format
  localparam int unsigned WordBits   = 64;
  localparam int unsigned ActBits    = 3;
  localparam int unsigned IdxBits    = 2;
  localparam int unsigned PassBits   = 9;

  // Defaults
  localparam int unsigned DefaultWidth = 256;
  localparam logic [PassBits-1:0] PassesReset = 9'd64;

  // Input actions
  localparam logic [ActBits-1:0] ActLoadA  = 3'd0;
  localparam logic [ActBits-1:0] ActLoadB  = 3'd1;
  localparam logic [ActBits-1:0] ActLoadP  = 3'd2;
  localparam logic [ActBits-1:0] ActPublic = 3'd3;
  localparam logic [ActBits-1:0] ActShared = 3'd4;

  // Controller to datapath commands
  typedef struct packed {
    logic               load_a;    // write word of secret A
    logic               load_b;    // write word of secret B
    logic               load_p;    // write word of peer value
    logic               init_pub;  // working <= A
    logic               init_shr;  // working <= peer
    logic               round;     // working <= one round
    logic               emit;      // capture one result word
    logic               xor_a;     // fold A into emitted word
    logic [IdxBits-1:0] word_sel;  // word being emitted
  } cmd_t;

endpackage

### rtl/fke_datapath.sv
// ----------------------------------------------------------------------------
// fke_datapath: operand storage, round logic and result word register
// Holds A, B, peer and working values; one full round per enabled cycle.
// ----------------------------------------------------------------------------
module fke_datapath #(
  parameter int unsigned WIDTH = fke_pkg::DefaultWidth
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  fke_pkg::cmd_t                       cmd_i,
  input  logic [fke_pkg::IdxBits-1:0]         word_index_i,
  input  logic [fke_pkg::WordBits-1:0]        word_data_i,
  output logic [fke_pkg::IdxBits-1:0]         out_index_o,
  output logic [fke_pkg::WordBits-1:0]        out_word_o,
  output logic                                last_word_o
);
  import fke_pkg::*;

  localparam int unsigned Words   = (WIDTH + WordBits - 1) / WordBits;
  localparam int unsigned Store   = Words * WordBits;
  localparam int unsigned TopBits = WIDTH - (Words - 1) * WordBits;
  localparam logic [WordBits-1:0] TopMask =
    (TopBits >= WordBits) ? {WordBits{1'b1}} : WordBits'((65'd1 << TopBits) - 65'd1);
  localparam logic [IdxBits-1:0] LastIdx = IdxBits'(Words - 1);

  logic [Store-1:0]    a_q, b_q, p_q, w_q, w_d;
  logic [WIDTH-1:0]    nxt;
  logic [WordBits-1:0] load_word;
  logic [WordBits-1:0] emit_word;

  // Top word drops bits at or above WIDTH
  assign load_word = (word_index_i == LastIdx) ? (word_data_i & TopMask) : word_data_i;

  // Operand loads, word enable decoded per word
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < Words; k++) begin
      if (word_index_i == IdxBits'(k)) begin
        if (cmd_i.load_a) a_q[k*WordBits +: WordBits] <= load_word;
        if (cmd_i.load_b) b_q[k*WordBits +: WordBits] <= load_word;
        if (cmd_i.load_p) p_q[k*WordBits +: WordBits] <= load_word;
      end
    end
  end

  // One round: cyclic three-bit neighborhood XOR of both operands, bit-reversed
  always_comb begin
    for (int i = 0; i < WIDTH; i++) begin
      nxt[WIDTH-1-i] = w_q[(i + WIDTH - 1) % WIDTH] ^ w_q[i] ^ w_q[(i + 1) % WIDTH]
                     ^ b_q[(i + WIDTH - 1) % WIDTH] ^ b_q[i] ^ b_q[(i + 1) % WIDTH];
    end
  end

  // Working value update
  always_comb begin
    w_d = w_q;
    if (cmd_i.init_pub)      w_d = a_q;
    else if (cmd_i.init_shr) w_d = p_q;
    else if (cmd_i.round)    w_d = Store'(nxt);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_q <= '0;
    end else begin
      w_q <= w_d;
    end
  end

  // Result word select, A folded in for the shared value
  always_comb begin
    emit_word = '0;
    for (int k = 0; k < Words; k++) begin
      if (cmd_i.word_sel == IdxBits'(k)) begin
        emit_word = w_q[k*WordBits +: WordBits]
                  ^ (cmd_i.xor_a ? a_q[k*WordBits +: WordBits] : '0);
      end
    end
  end

  // Result payload register
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_index_o <= cmd_i.word_sel;
      out_word_o  <= emit_word;
      last_word_o <= (cmd_i.word_sel == LastIdx);
    end
  end

endmodule

### rtl/fke_ctrl.sv
// ----------------------------------------------------------------------------
// fke_ctrl: sequencing of loads, round iterations and word output
// Holds the pass count register, round counter, word counter and out valid.
// ----------------------------------------------------------------------------
module fke_ctrl #(
  parameter int unsigned WIDTH = fke_pkg::DefaultWidth
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [fke_pkg::ActBits-1:0]   action_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [fke_pkg::PassBits-1:0]  cfg_data_i,
  output fke_pkg::cmd_t                 cmd_o
);
  import fke_pkg::*;

  localparam int unsigned Words = (WIDTH + WordBits - 1) / WordBits;
  localparam logic [IdxBits-1:0]  LastIdx  = IdxBits'(Words - 1);
  localparam logic [PassBits-1:0] WidthCnt = PassBits'(WIDTH);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StRun  = 2'd1;
  localparam logic [1:0] StEmit = 2'd2;

  logic [1:0]          state_q, state_d;
  logic [PassBits-1:0] passes_q, passes_d;
  logic [PassBits-1:0] rounds_q, rounds_d;
  logic [IdxBits-1:0]  word_q, word_d;
  logic                shared_q, shared_d;
  logic                out_valid_q, out_valid_d;
  logic                in_xfer, out_free;
  logic [PassBits-1:0] shared_rounds;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != StIdle);
  assign out_valid_o = out_valid_q;
  assign in_xfer     = in_valid_i && (state_q == StIdle);
  assign out_free    = !out_valid_q || !out_stall_i;

  // Shared run count saturates at zero
  assign shared_rounds = (passes_q > WidthCnt) ? '0 : (WidthCnt - passes_q);

  // Next state and command decode
  always_comb begin
    state_d     = state_q;
    passes_d    = passes_q;
    rounds_d    = rounds_q;
    word_d      = word_q;
    shared_d    = shared_q;
    out_valid_d = out_valid_q;
    cmd_o       = '0;
    cmd_o.xor_a    = shared_q;
    cmd_o.word_sel = word_q;

    if (cfg_valid_i) passes_d = cfg_data_i;

    // Output register drains on transfer
    if (out_valid_q && !out_stall_i) out_valid_d = 1'b0;

    case (state_q)
      StIdle: begin
        if (in_xfer) begin
          case (action_i)
            ActLoadA: cmd_o.load_a = 1'b1;
            ActLoadB: cmd_o.load_b = 1'b1;
            ActLoadP: cmd_o.load_p = 1'b1;
            ActPublic: begin
              cmd_o.init_pub = 1'b1;
              rounds_d = passes_q;
              shared_d = 1'b0;
              state_d  = StRun;
            end
            ActShared: begin
              cmd_o.init_shr = 1'b1;
              rounds_d = shared_rounds;
              shared_d = 1'b1;
              state_d  = StRun;
            end
            default: ;
          endcase
        end
      end
      StRun: begin
        if (rounds_q == '0) begin
          word_d  = '0;
          state_d = StEmit;
        end else begin
          cmd_o.round = 1'b1;
          rounds_d = rounds_q - PassBits'(1);
        end
      end
      StEmit: begin
        if (out_free) begin
          cmd_o.emit  = 1'b1;
          out_valid_d = 1'b1;
          word_d      = word_q + IdxBits'(1);
          if (word_q == LastIdx) state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      passes_q    <= PassesReset;
      rounds_q    <= '0;
      word_q      <= '0;
      shared_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      passes_q    <= passes_d;
      rounds_q    <= rounds_d;
      word_q      <= word_d;
      shared_q    <= shared_d;
      out_valid_q <= out_valid_d;
    end
  end

  // A held result word is never overwritten
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |-> !cmd_o.emit)
    else $error("result word overwritten while stalled");

  // Rounds run only while the counter is nonzero
  a_round_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.round |-> (state_q == StRun) && (rounds_q != '0))
    else $error("round issued with no rounds left");

  // Exhausted counter moves to word output
  a_run_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StRun && rounds_q == '0) |=> (state_q == StEmit && word_q == '0))
    else $error("run did not hand over to word output");

  // Final word returns the engine to idle with a valid result
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.emit && word_q == LastIdx) |=> (state_q == StIdle && out_valid_q))
    else $error("last word did not end the run");

endmodule

### rtl/fscx_key_exchange.sv
// ----------------------------------------------------------------------------
// fscx_key_exchange: surroundings-XOR key exchange engine
// Loads A, B and peer operands by 64-bit word; runs public and shared commands.
// ----------------------------------------------------------------------------
// A public or shared command applies N rounds and then emits its result as
// WIDTH/64 words (rounded up), where N is public_passes for the public command
// and WIDTH - public_passes (zero if negative) for the shared one. The round
// loop applies one full round to the working register per cycle, and the
// single output register holds one word at a time and can stretch the output
// phase under stall. Input is stalled for the whole command; loads are taken
// again while the last result word still waits.
// The configuration write may be issued at any cycle while the engine is idle.
module fscx_key_exchange #(
  parameter int unsigned WIDTH = fke_pkg::DefaultWidth
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [fke_pkg::ActBits-1:0]   action_i,
  input  logic [fke_pkg::IdxBits-1:0]   word_index_i,
  input  logic [fke_pkg::WordBits-1:0]  word_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [fke_pkg::IdxBits-1:0]   out_index_o,
  output logic [fke_pkg::WordBits-1:0]  out_word_o,
  output logic                          last_word_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [fke_pkg::PassBits-1:0]  cfg_data_i
);
  import fke_pkg::*;

  cmd_t cmd;

  // Sequencer
  fke_ctrl #(.WIDTH(WIDTH)) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .action_i    (action_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .cmd_o       (cmd)
  );

  // Operand storage and round logic
  fke_datapath #(.WIDTH(WIDTH)) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .word_index_i (word_index_i),
    .word_data_i  (word_data_i),
    .out_index_o  (out_index_o),
    .out_word_o   (out_word_o),
    .last_word_o  (last_word_o)
  );

endmodule
